>>> src/tms_pkg.sv
`default_nettype none

package tms_pkg;

   // sizes of the tape and the program store
   localparam int TAPE_CELLS    = 32768;
   localparam int PROGRAM_BYTES = 4096;
   localparam int PTR_W         = $clog2(TAPE_CELLS);
   localparam int PADDR_W       = $clog2(PROGRAM_BYTES);
   localparam int PC_W          = $clog2(PROGRAM_BYTES + 1);
   localparam int CELL_W        = 8;
   localparam int STAT_W        = 3;

   // input commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OUT   = 3'd0;
   localparam logic [STAT_W-1:0] STAT_END   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OPEN  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_CLOSE = 3'd3;
   localparam logic [STAT_W-1:0] STAT_COMMA = 3'd4;
   localparam logic [STAT_W-1:0] STAT_TAPE  = 3'd5;
   localparam logic [STAT_W-1:0] STAT_FULL  = 3'd6;
   localparam logic [STAT_W-1:0] STAT_RUN   = 3'd0;

   // instruction bytes
   localparam logic [7:0] OP_INC   = 8'h2B;
   localparam logic [7:0] OP_DEC   = 8'h2D;
   localparam logic [7:0] OP_RIGHT = 8'h3E;
   localparam logic [7:0] OP_LEFT  = 8'h3C;
   localparam logic [7:0] OP_OPEN  = 8'h5B;
   localparam logic [7:0] OP_CLOSE = 8'h5D;
   localparam logic [7:0] OP_DOT   = 8'h2E;
   localparam logic [7:0] OP_COMMA = 8'h2C;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_FWD,
      S_BACK,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> src/tms_ram.sv
`default_nettype none

module tms_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/tape_machine_step.sv
`default_nettype none

// Tape machine interpreter. A word with req_cmd low appends req_prog_byte to the
// program store; it gives a result only when the store is full. A word with
// req_cmd high runs one instruction, or reports a stop code once the machine
// has stopped or run past the program. The program store and current tape cell
// are read as the word is taken; the instruction executes in the cycle after.
// A bracket that scans for its partner reads the program store byte by byte.
// A result goes straight to the output register when that register is free,
// and new words are taken while a result waits there. After reset the tape
// memory is cleared one cell per cycle, 32768 cells, while req_ready is low.
module tape_machine_step (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_cmd,
   input  wire logic [7:0]                  req_prog_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic [tms_pkg::STAT_W-1:0]       rsp_status
);

   localparam int PTR_W   = tms_pkg::PTR_W;
   localparam int PC_W    = tms_pkg::PC_W;
   localparam int PADDR_W = tms_pkg::PADDR_W;
   localparam int STAT_W  = tms_pkg::STAT_W;
   localparam int CELL_W  = tms_pkg::CELL_W;

   tms_pkg::state_type state_ff, state_in;

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [PC_W-1:0]   len_ff, len_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [STAT_W-1:0] stop_ff, stop_in;
   logic [PTR_W-1:0]  clr_ff, clr_in;
   logic [PC_W-1:0]   scan_ff, scan_in;
   logic [PC_W-1:0]   depth_ff, depth_in;
   logic [CELL_W-1:0] pend_byte_ff, pend_byte_in;
   logic [STAT_W-1:0] pend_stat_ff, pend_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic               p_we;
   logic [PADDR_W-1:0] p_waddr;
   logic [PADDR_W-1:0] p_raddr;
   logic [7:0]         p_rdata;
   logic               t_we;
   logic [PTR_W-1:0]   t_waddr;
   logic [CELL_W-1:0]  t_wdata;
   logic [CELL_W-1:0]  t_rdata;

   logic              emit;
   logic [CELL_W-1:0] emit_byte;
   logic [STAT_W-1:0] emit_stat;
   logic              halt_req;
   logic [STAT_W-1:0] halt_code;
   logic              slot_free;

   logic [PC_W-1:0] pc_inc, pc_dec, scan_inc, scan_dec;

   assign pc_inc   = pc_ff + PC_W'(1);
   assign pc_dec   = pc_ff - PC_W'(1);
   assign scan_inc = scan_ff + PC_W'(1);
   assign scan_dec = scan_ff - PC_W'(1);
   assign p_waddr  = len_ff[PADDR_W-1:0];

   // program store and tape
   tms_ram #(
      .DEPTH(tms_pkg::PROGRAM_BYTES),
      .WIDTH(8)
   ) u_prog (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (req_prog_byte),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   tms_ram #(
      .DEPTH(tms_pkg::TAPE_CELLS),
      .WIDTH(CELL_W)
   ) u_tape (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (ptr_ff),
      .rd_data (t_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tms_pkg::S_CLEAR;
         pc_ff        <= '0;
         len_ff       <= '0;
         ptr_ff       <= '0;
         stop_ff      <= tms_pkg::STAT_RUN;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         stop_ff      <= stop_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      depth_ff     <= depth_in;
      pend_byte_ff <= pend_byte_in;
      pend_stat_ff <= pend_stat_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      depth_in     = depth_ff;
      pend_byte_in = pend_byte_ff;
      pend_stat_in = pend_stat_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_stat_in  = rsp_stat_ff;
      p_we         = 1'b0;
      p_raddr      = pc_ff[PADDR_W-1:0];
      t_we         = 1'b0;
      t_waddr      = ptr_ff;
      t_wdata      = t_rdata + CELL_W'(1);
      emit         = 1'b0;
      emit_byte    = '0;
      emit_stat    = tms_pkg::STAT_OUT;
      halt_req     = 1'b0;
      halt_code    = tms_pkg::STAT_RUN;
      req_ready    = (state_ff == tms_pkg::S_IDLE);

      case (state_ff)
         // tape clearing pass after reset
         tms_pkg::S_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            t_wdata = '0;
            clr_in  = clr_ff + PTR_W'(1);
            if (clr_ff == PTR_W'(tms_pkg::TAPE_CELLS - 1)) begin
               state_in = tms_pkg::S_IDLE;
            end
         end

         // take a word; program and tape reads go out here
         tms_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == tms_pkg::CMD_LOAD) begin
                  if (len_ff == PC_W'(tms_pkg::PROGRAM_BYTES)) begin
                     emit      = 1'b1;
                     emit_stat = tms_pkg::STAT_FULL;
                  end else begin
                     p_we   = 1'b1;
                     len_in = len_ff + PC_W'(1);
                  end
               end else if (stop_ff != tms_pkg::STAT_RUN) begin
                  emit      = 1'b1;
                  emit_stat = stop_ff;
               end else if (pc_ff >= len_ff) begin
                  halt_req  = 1'b1;
                  halt_code = tms_pkg::STAT_END;
               end else begin
                  state_in = tms_pkg::S_EXEC;
               end
            end
         end

         // execute the fetched instruction against the fetched cell
         tms_pkg::S_EXEC: begin
            state_in = tms_pkg::S_IDLE;
            case (p_rdata)
               tms_pkg::OP_INC: begin
                  t_we    = 1'b1;
                  t_wdata = t_rdata + CELL_W'(1);
                  pc_in   = pc_inc;
               end
               tms_pkg::OP_DEC: begin
                  t_we    = 1'b1;
                  t_wdata = t_rdata - CELL_W'(1);
                  pc_in   = pc_inc;
               end
               tms_pkg::OP_RIGHT: begin
                  if (ptr_ff == PTR_W'(tms_pkg::TAPE_CELLS - 1)) begin
                     halt_req  = 1'b1;
                     halt_code = tms_pkg::STAT_TAPE;
                  end else begin
                     ptr_in = ptr_ff + PTR_W'(1);
                     pc_in  = pc_inc;
                  end
               end
               tms_pkg::OP_LEFT: begin
                  if (ptr_ff == '0) begin
                     halt_req  = 1'b1;
                     halt_code = tms_pkg::STAT_TAPE;
                  end else begin
                     ptr_in = ptr_ff - PTR_W'(1);
                     pc_in  = pc_inc;
                  end
               end
               tms_pkg::OP_DOT: begin
                  pc_in     = pc_inc;
                  emit      = 1'b1;
                  emit_byte = t_rdata;
                  emit_stat = tms_pkg::STAT_OUT;
               end
               tms_pkg::OP_COMMA: begin
                  halt_req  = 1'b1;
                  halt_code = tms_pkg::STAT_COMMA;
               end
               tms_pkg::OP_OPEN: begin
                  if (pc_inc >= len_ff) begin
                     halt_req  = 1'b1;
                     halt_code = tms_pkg::STAT_OPEN;
                  end else begin
                     scan_in  = pc_inc;
                     depth_in = '0;
                     p_raddr  = pc_inc[PADDR_W-1:0];
                     state_in = tms_pkg::S_FWD;
                  end
               end
               tms_pkg::OP_CLOSE: begin
                  if (pc_ff == '0) begin
                     halt_req  = 1'b1;
                     halt_code = tms_pkg::STAT_CLOSE;
                  end else begin
                     scan_in  = pc_dec;
                     depth_in = '0;
                     p_raddr  = pc_dec[PADDR_W-1:0];
                     state_in = tms_pkg::S_BACK;
                  end
               end
               default: begin
                  pc_in = pc_inc;
               end
            endcase
         end

         // forward scan, one program byte a cycle
         tms_pkg::S_FWD: begin
            if (p_rdata == tms_pkg::OP_CLOSE && depth_ff == '0) begin
               pc_in    = (t_rdata == '0) ? scan_inc : pc_inc;
               state_in = tms_pkg::S_IDLE;
            end else begin
               if (p_rdata == tms_pkg::OP_OPEN) begin
                  depth_in = depth_ff + PC_W'(1);
               end else if (p_rdata == tms_pkg::OP_CLOSE) begin
                  depth_in = depth_ff - PC_W'(1);
               end
               if (scan_inc >= len_ff) begin
                  halt_req  = 1'b1;
                  halt_code = tms_pkg::STAT_OPEN;
                  state_in  = tms_pkg::S_IDLE;
               end else begin
                  scan_in = scan_inc;
                  p_raddr = scan_inc[PADDR_W-1:0];
               end
            end
         end

         // backward scan, one program byte a cycle
         tms_pkg::S_BACK: begin
            if (p_rdata == tms_pkg::OP_OPEN && depth_ff == '0) begin
               pc_in    = (t_rdata != '0) ? scan_inc : pc_inc;
               state_in = tms_pkg::S_IDLE;
            end else begin
               if (p_rdata == tms_pkg::OP_CLOSE) begin
                  depth_in = depth_ff + PC_W'(1);
               end else if (p_rdata == tms_pkg::OP_OPEN) begin
                  depth_in = depth_ff - PC_W'(1);
               end
               if (scan_ff == '0) begin
                  halt_req  = 1'b1;
                  halt_code = tms_pkg::STAT_CLOSE;
                  state_in  = tms_pkg::S_IDLE;
               end else begin
                  scan_in = scan_dec;
                  p_raddr = scan_dec[PADDR_W-1:0];
               end
            end
         end

         tms_pkg::S_EMIT: begin
            state_in = tms_pkg::S_EMIT;
         end

         default: begin
            state_in = tms_pkg::S_IDLE;
         end
      endcase

      // a stop latches its code and reports it
      if (halt_req) begin
         stop_in   = halt_code;
         emit      = 1'b1;
         emit_byte = '0;
         emit_stat = halt_code;
      end

      // output register, with one pending word held back when it is busy
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == tms_pkg::S_EMIT) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pend_byte_ff;
            rsp_stat_in  = pend_stat_ff;
            state_in     = tms_pkg::S_IDLE;
         end
      end else if (emit) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = emit_byte;
            rsp_stat_in  = emit_stat;
         end else begin
            pend_byte_in = emit_byte;
            pend_stat_in = emit_stat;
            state_in     = tms_pkg::S_EMIT;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_status   = rsp_stat_ff;

   // cell pointer never leaves the tape
   a_ptr_on_tape: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(tms_pkg::TAPE_CELLS - 1))
      else $error("cell pointer off tape");

   // program counter never runs past the loaded program
   a_pc_in_prog: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= len_ff)
      else $error("program counter past program length");

   // store length bounded by its depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PC_W'(tms_pkg::PROGRAM_BYTES))
      else $error("program length beyond store");

   // a dropped append never grows the store
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tms_pkg::S_IDLE && req_valid && req_cmd == tms_pkg::CMD_LOAD
       && len_ff == PC_W'(tms_pkg::PROGRAM_BYTES)) |=> $stable(len_ff))
      else $error("append grew a full store");

endmodule

`default_nettype wire
